// File: sv/rmss_pkg.sv
// Shared constants, types and saturating arithmetic helpers for the
// repeated max subarray sum block. No dependencies.
package rmss_pkg;

	localparam int SAMPLE_WIDTH  = 32;
	localparam int ACC_WIDTH     = 64;
	localparam int COUNT_WIDTH   = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
	localparam int SPLIT         = 32;
	localparam int LO_WIDTH      = SPLIT + COUNT_WIDTH;
	localparam int HI_WIDTH      = ACC_WIDTH - 1 - SPLIT + COUNT_WIDTH;
	localparam int PROD_WIDTH    = ACC_WIDTH + COUNT_WIDTH;
	localparam int REPEAT_OFFSET = 2;

	typedef logic signed [ACC_WIDTH-1:0] acc_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam acc_t ACC_MAX   = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam acc_t ACC_MIN   = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam acc_t BEST_INIT = {{(ACC_WIDTH-31){1'b1}}, 31'b0};
	localparam count_t REPEAT_ONE = count_t'(1);

	typedef struct packed {
		acc_t best_run;
		acc_t prefix_total;
		acc_t least_prefix;
		acc_t best_prefix;
	} rmss_rec_t;

	typedef struct packed {
		logic      valid;
		rmss_rec_t rec;
	} rmss_push_t;

	function automatic acc_t sat_add(input acc_t a, input acc_t b);
		acc_t s;
		s = a + b;
		if (a[ACC_WIDTH-1] == b[ACC_WIDTH-1] && s[ACC_WIDTH-1] != a[ACC_WIDTH-1])
			return a[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
		return s;
	endfunction

	function automatic acc_t sat_sub(input acc_t a, input acc_t b);
		acc_t d;
		d = a - b;
		if (a[ACC_WIDTH-1] != b[ACC_WIDTH-1] && d[ACC_WIDTH-1] != a[ACC_WIDTH-1])
			return a[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
		return d;
	endfunction

endpackage

// File: sv/rmss_front.sv
// Front end: accepts samples and keeps the five running accumulators.
// Pushes a finished array's summary to the queue. Depends on rmss_pkg.
module rmss_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             sample,
	input  logic                    last_sample,
	input  logic                    queue_full,
	output rmss_pkg::rmss_push_t    push
);
	import rmss_pkg::*;

	acc_t run_sum_q;
	acc_t best_run_q;
	acc_t prefix_total_q;
	acc_t best_prefix_q;
	acc_t least_prefix_q;

	acc_t s_ext;
	acc_t least_nxt;
	acc_t prefix_nxt;
	acc_t best_prefix_nxt;
	acc_t run_raw;
	acc_t best_run_nxt;
	acc_t run_nxt;
	logic accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign s_ext    = acc_t'($signed(sample[SAMPLE_WIDTH-1:0]));

	always_comb begin
		least_nxt       = (prefix_total_q < least_prefix_q) ? prefix_total_q : least_prefix_q;
		prefix_nxt      = sat_add(prefix_total_q, s_ext);
		best_prefix_nxt = (prefix_nxt > best_prefix_q) ? prefix_nxt : best_prefix_q;
		run_raw         = sat_add(run_sum_q, s_ext);
		best_run_nxt    = (run_raw > best_run_q) ? run_raw : best_run_q;
		run_nxt         = run_raw[ACC_WIDTH-1] ? '0 : run_raw;
	end

	assign push.valid             = accept && last_sample;
	assign push.rec.best_run      = best_run_nxt;
	assign push.rec.prefix_total  = prefix_nxt;
	assign push.rec.least_prefix  = least_nxt;
	assign push.rec.best_prefix   = best_prefix_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_sum_q      <= '0;
			best_run_q     <= BEST_INIT;
			prefix_total_q <= '0;
			best_prefix_q  <= BEST_INIT;
			least_prefix_q <= '0;
		end else if (accept) begin
			if (last_sample) begin
				run_sum_q      <= '0;
				best_run_q     <= BEST_INIT;
				prefix_total_q <= '0;
				best_prefix_q  <= BEST_INIT;
				least_prefix_q <= '0;
			end else begin
				run_sum_q      <= run_nxt;
				best_run_q     <= best_run_nxt;
				prefix_total_q <= prefix_nxt;
				best_prefix_q  <= best_prefix_nxt;
				least_prefix_q <= least_nxt;
			end
		end
	end

endmodule

// File: sv/rmss_fifo.sv
// Short queue of array summaries between the front and back ends.
// Depends on rmss_pkg.
module rmss_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmss_pkg::rmss_push_t push,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output rmss_pkg::rmss_rec_t  head
);
	import rmss_pkg::*;

	rmss_rec_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0]     wr_ptr_q;
	logic [QPTR_WIDTH-1:0]     rd_ptr_q;
	logic [QCNT_WIDTH-1:0]     count_q;

	assign full  = (count_q == QCNT_WIDTH'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + QPTR_WIDTH'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_WIDTH'(1);
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + QCNT_WIDTH'(1);
				2'b01:   count_q <= count_q - QCNT_WIDTH'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> count_q == $past(count_q) + QCNT_WIDTH'(1))
		else $error("queue count lost a push");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_WIDTH'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: sv/rmss_back.sv
// Back end: turns an array summary into the saturated result over a
// three-stage pipeline and an output register. Depends on rmss_pkg.
module rmss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rmss_pkg::count_t    repeat_count,
	input  logic                queue_empty,
	input  rmss_pkg::rmss_rec_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         max_sum
);
	import rmss_pkg::*;

	logic advance;

	logic                  v_s1;
	acc_t                  suffix_s1;
	acc_t                  best_prefix_s1;
	acc_t                  best_run_s1;
	logic [LO_WIDTH-1:0]   lo_s1;
	logic [HI_WIDTH-1:0]   hi_s1;
	logic                  nonneg_s1;
	logic                  kadane_s1;

	logic                  v_s2;
	acc_t                  cand_s2;
	acc_t                  best_run_s2;
	logic [PROD_WIDTH-1:0] prod_s2;
	logic                  nonneg_s2;
	logic                  kadane_s2;

	logic                  v_s3;
	acc_t                  cand_s3;
	acc_t                  best_run_s3;
	logic                  kadane_s3;

	logic                  out_valid_q;
	acc_t                  max_sum_q;

	count_t                mult;
	acc_t                  prod_sat;
	acc_t                  addend;

	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && !queue_empty;
	assign mult      = repeat_count - count_t'(REPEAT_OFFSET);
	assign out_valid = out_valid_q;
	assign max_sum   = max_sum_q;

	always_comb begin
		if (prod_s2[PROD_WIDTH-1:ACC_WIDTH-1] != '0)
			prod_sat = ACC_MAX;
		else
			prod_sat = acc_t'(prod_s2[ACC_WIDTH-1:0]);
		addend = nonneg_s2 ? prod_sat : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			suffix_s1      <= sat_sub(head.prefix_total, head.least_prefix);
			best_prefix_s1 <= head.best_prefix;
			best_run_s1    <= head.best_run;
			lo_s1          <= LO_WIDTH'(head.prefix_total[SPLIT-1:0]) * LO_WIDTH'(mult);
			hi_s1          <= HI_WIDTH'(head.prefix_total[ACC_WIDTH-2:SPLIT])
				* HI_WIDTH'(mult);
			nonneg_s1      <= !head.prefix_total[ACC_WIDTH-1];
			kadane_s1      <= (repeat_count <= REPEAT_ONE);

			cand_s2        <= sat_add(suffix_s1, best_prefix_s1);
			best_run_s2    <= best_run_s1;
			prod_s2        <= (PROD_WIDTH'(hi_s1) << SPLIT) + PROD_WIDTH'(lo_s1);
			nonneg_s2      <= nonneg_s1;
			kadane_s2      <= kadane_s1;

			cand_s3        <= sat_add(cand_s2, addend);
			best_run_s3    <= best_run_s2;
			kadane_s3      <= kadane_s2;

			if (kadane_s3 || best_run_s3 >= cand_s3)
				max_sum_q <= best_run_s3;
			else
				max_sum_q <= cand_s3;
		end
	end

`ifndef SYNTHESIS
	a_pop_feeds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1) else $error("popped summary not in first stage");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> v_s3 == $past(v_s3) && v_s2 == $past(v_s2))
		else $error("pipeline moved during stall");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s3) |=> out_valid_q) else $error("result dropped at output");
`endif

endmodule

// File: sv/repeated_max_subarray_sum.sv
// Samples stream in one per cycle, with last_sample marking the end of
// an array; the front end keeps Kadane, prefix and least-prefix sums in a
// single adder/compare stage, so in_ready stays high unless the four-entry
// summary queue is full, as it becomes when the output stalls. Each
// array's max_sum follows its last sample through four registered stages:
// suffix and split 32x16/31x16 partial products, product combine, saturated
// add, final compare. The user must write repeat_count only while idle;
// the block does not enforce it. 0 and 1 both give the plain Kadane result.
module repeated_max_subarray_sum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] max_sum
);
	import rmss_pkg::*;

	count_t     repeat_count_q;
	rmss_push_t push;
	rmss_rec_t  head;
	logic       queue_full;
	logic       queue_empty;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			repeat_count_q <= REPEAT_ONE;
		else if (cfg_we)
			repeat_count_q <= cfg_wdata;
	end

	rmss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.last_sample (last_sample),
		.queue_full  (queue_full),
		.push        (push)
	);

	rmss_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.empty  (queue_empty),
		.head   (head)
	);

	rmss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.repeat_count (repeat_count_q),
		.queue_empty  (queue_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_sum      (max_sum)
	);

endmodule
